// ===== rtl/core/tlbfa_pkg.sv =====
`timescale 1ns / 1ps

package tlbfa_pkg;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int unsigned ASID_W     = 16;
  localparam int unsigned FLAGS_W    = 8;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Word index of the current ASID register on the configuration port.
  localparam logic REG_CURRENT_ASID = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP      = 3'd0,
    MODE_INSERT      = 3'd1,
    MODE_FLUSH_ALL   = 3'd2,
    MODE_FLUSH_ASID  = 3'd3,
    MODE_FLUSH_PAGE  = 3'd4
  } mode_e;

  // Operation handed from the input register to the entry array.
  typedef struct packed {
    logic                fire;
    logic [MODE_W-1:0]   mode;
    logic [PAGE_W-1:0]   vpage;
    logic [PAGE_W-1:0]   ppage;
    logic [FLAGS_W-1:0]  flags;
    logic [ASID_W-1:0]   flush_asid;
    logic [ASID_W-1:0]   cur_asid;
  } tlb_req_t;

  // Lookup answer from the entry array.
  typedef struct packed {
    logic                hit;
    logic [PAGE_W-1:0]   ppage;
    logic [FLAGS_W-1:0]  flags;
  } tlb_rsp_t;

endpackage

// ===== rtl/core/tlbfa_cfg.sv =====
`timescale 1ns / 1ps

module tlbfa_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tlbfa_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tlbfa_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tlbfa_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  output logic [tlbfa_pkg::ASID_W-1:0]        cur_asid_o
);

  logic [tlbfa_pkg::ASID_W-1:0] cur_asid_q;
  logic                         wr_en;
  logic                         word_idx;

  // Registers are word aligned, so the byte offset bits are ignored.
  assign word_idx = paddr[2];
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && (word_idx == tlbfa_pkg::REG_CURRENT_ASID);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_asid_q <= '0;
    end else if (wr_en) begin
      cur_asid_q <= pwdata[tlbfa_pkg::ASID_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (word_idx == tlbfa_pkg::REG_CURRENT_ASID) begin
      prdata = {{(tlbfa_pkg::APB_DATA_W - tlbfa_pkg::ASID_W){1'b0}}, cur_asid_q};
    end
  end

  assign cur_asid_o = cur_asid_q;

endmodule

// ===== rtl/core/tlbfa_array.sv =====
`timescale 1ns / 1ps

module tlbfa_array #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlbfa_pkg::tlb_req_t req_i,
  output tlbfa_pkg::tlb_rsp_t rsp_o
);

  localparam int unsigned PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(ENTRIES - 1);

  logic [ENTRIES-1:0]                 valid_q, valid_d;
  logic [tlbfa_pkg::PAGE_W-1:0]       vpage_q [ENTRIES];
  logic [tlbfa_pkg::PAGE_W-1:0]       ppage_q [ENTRIES];
  logic [tlbfa_pkg::ASID_W-1:0]       asid_q  [ENTRIES];
  logic [tlbfa_pkg::FLAGS_W-1:0]      flags_q [ENTRIES];
  logic [PTR_W-1:0]                   ptr_q, ptr_d;

  logic [ENTRIES-1:0] page_eq;
  logic [ENTRIES-1:0] asid_eq;
  logic [ENTRIES-1:0] fasid_eq;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] first;
  logic               do_insert;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      page_eq[i]  = (vpage_q[i] == req_i.vpage);
      asid_eq[i]  = (asid_q[i] == req_i.cur_asid);
      fasid_eq[i] = (asid_q[i] == req_i.flush_asid);
    end
  end

  assign match = valid_q & page_eq & asid_eq;
  // Isolate the lowest set bit so that duplicates resolve to the lowest index.
  assign first = match & (~match + ENTRIES'(1));

  always_comb begin
    rsp_o.hit   = |match;
    rsp_o.ppage = '0;
    rsp_o.flags = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rsp_o.ppage = rsp_o.ppage | (ppage_q[i] & {tlbfa_pkg::PAGE_W{first[i]}});
      rsp_o.flags = rsp_o.flags | (flags_q[i] & {tlbfa_pkg::FLAGS_W{first[i]}});
    end
  end

  always_comb begin
    valid_d   = valid_q;
    ptr_d     = ptr_q;
    do_insert = 1'b0;
    if (req_i.fire) begin
      case (tlbfa_pkg::mode_e'(req_i.mode))
        tlbfa_pkg::MODE_INSERT: begin
          do_insert       = 1'b1;
          valid_d[ptr_q]  = 1'b1;
          ptr_d           = (ptr_q == LAST_IDX) ? '0 : ptr_q + PTR_W'(1);
        end
        tlbfa_pkg::MODE_FLUSH_ALL: begin
          valid_d = '0;
        end
        tlbfa_pkg::MODE_FLUSH_ASID: begin
          valid_d = valid_q & ~fasid_eq;
        end
        tlbfa_pkg::MODE_FLUSH_PAGE: begin
          valid_d = valid_q & ~page_eq;
        end
        default: begin
          valid_d = valid_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      vpage_q[ptr_q] <= req_i.vpage;
      ppage_q[ptr_q] <= req_i.ppage;
      asid_q[ptr_q]  <= req_i.cur_asid;
      flags_q[ptr_q] <= req_i.flags;
    end
  end

endmodule

// ===== rtl/core/tlb_fully_associative_asid.sv =====
`timescale 1ns / 1ps

// Fully associative TLB with 4 KiB pages and ASID tags.
// Input channel: in_valid_i / in_stall_o carry one operation per transaction
// (lookup, insert, flush all, flush by ASID, flush by page). Every input
// transaction gives exactly one result transaction on out_valid_o / out_stall_i.
// An accepted transaction is held in the input register, where all entries
// are compared in parallel, and its result is then captured in the output
// register. Throughput is one transaction per cycle while the receiver does
// not stall; the entry array and the counters are updated at the same edge
// as the result is captured, so back-to-back operations see each other's
// effects in order.
// When the receiver stalls, the result is held and the input register keeps
// its transaction, after which in_stall_o is raised until the result is taken.
// The current ASID is set through the APB port at byte address 0 and should
// only be written while no transaction is in flight.
// Reset clears all valid bits, the replacement pointer, both counters and the
// current ASID; entry contents are left as they are.

module tlb_fully_associative_asid #(
  parameter int unsigned TLB_ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tlbfa_pkg::MODE_W-1:0]        mode_i,
  input  logic [tlbfa_pkg::ADDR_W-1:0]        virtual_address_i,
  input  logic [tlbfa_pkg::ADDR_W-1:0]        physical_page_address_i,
  input  logic [tlbfa_pkg::FLAGS_W-1:0]       entry_flags_i,
  input  logic [tlbfa_pkg::ASID_W-1:0]        flush_asid_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [tlbfa_pkg::ADDR_W-1:0]        translated_address_o,
  output logic [tlbfa_pkg::FLAGS_W-1:0]       flags_out_o,
  output logic [tlbfa_pkg::COUNT_W-1:0]       hit_count_o,
  output logic [tlbfa_pkg::COUNT_W-1:0]       miss_count_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tlbfa_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tlbfa_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tlbfa_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam int unsigned PS = tlbfa_pkg::PAGE_SHIFT;

  logic [tlbfa_pkg::ASID_W-1:0]   cur_asid;

  logic                           s1_valid_q;
  logic [tlbfa_pkg::MODE_W-1:0]   s1_mode_q;
  logic [tlbfa_pkg::ADDR_W-1:0]   s1_va_q;
  logic [tlbfa_pkg::ADDR_W-1:0]   s1_pa_q;
  logic [tlbfa_pkg::FLAGS_W-1:0]  s1_flags_q;
  logic [tlbfa_pkg::ASID_W-1:0]   s1_fasid_q;

  logic                           advance;
  logic                           accept;
  logic                           is_lookup;

  tlbfa_pkg::tlb_req_t            req;
  tlbfa_pkg::tlb_rsp_t            rsp;

  logic [tlbfa_pkg::COUNT_W-1:0]  hits_q, hits_d;
  logic [tlbfa_pkg::COUNT_W-1:0]  misses_q, misses_d;

  logic                           out_valid_q;
  logic                           out_hit_q;
  logic [tlbfa_pkg::ADDR_W-1:0]   out_xlat_q;
  logic [tlbfa_pkg::FLAGS_W-1:0]  out_flags_q;
  logic [tlbfa_pkg::COUNT_W-1:0]  out_hits_q;
  logic [tlbfa_pkg::COUNT_W-1:0]  out_misses_q;

  tlbfa_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cur_asid_o (cur_asid)
  );

  // The input register moves on whenever the output register is free or
  // being emptied in this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q  <= mode_i;
      s1_va_q    <= virtual_address_i;
      s1_pa_q    <= physical_page_address_i;
      s1_flags_q <= entry_flags_i;
      s1_fasid_q <= flush_asid_i;
    end
  end

  always_comb begin
    req.fire       = advance;
    req.mode       = s1_mode_q;
    req.vpage      = s1_va_q[tlbfa_pkg::ADDR_W-1:PS];
    req.ppage      = s1_pa_q[tlbfa_pkg::ADDR_W-1:PS];
    req.flags      = s1_flags_q;
    req.flush_asid = s1_fasid_q;
    req.cur_asid   = cur_asid;
  end

  tlbfa_array #(
    .ENTRIES (TLB_ENTRIES)
  ) u_array (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign is_lookup = (tlbfa_pkg::mode_e'(s1_mode_q) == tlbfa_pkg::MODE_LOOKUP);

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    if (is_lookup) begin
      if (rsp.hit) begin
        hits_d = hits_q + tlbfa_pkg::COUNT_W'(1);
      end else begin
        misses_d = misses_q + tlbfa_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        hits_q      <= hits_d;
        misses_q    <= misses_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hit_q    <= is_lookup && rsp.hit;
      out_xlat_q   <= (is_lookup && rsp.hit) ? {rsp.ppage, s1_va_q[PS-1:0]} : '0;
      out_flags_q  <= (is_lookup && rsp.hit) ? rsp.flags : '0;
      out_hits_q   <= hits_d;
      out_misses_q <= misses_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign hit_o                = out_hit_q;
  assign translated_address_o = out_xlat_q;
  assign flags_out_o          = out_flags_q;
  assign hit_count_o          = out_hits_q;
  assign miss_count_o         = out_misses_q;

endmodule
